FILE: src/mcft_pkg.sv
// Shared types, constants and the CRC-8 byte update for the Manchester frame transmitter.
package mcft_pkg;

  localparam int unsigned PayloadBytes = 3;
  localparam int unsigned PayloadW     = 8 * PayloadBytes;
  localparam int unsigned FrameBits    = 8 * (PayloadBytes + 1);
  localparam int unsigned CellCntW     = $clog2(FrameBits + 1);
  localparam int unsigned ByteIdxW     = $clog2(PayloadBytes + 1);

  localparam logic [7:0] CrcPoly = 8'h07;
  localparam logic [7:0] CrcInit = 8'h00;
  localparam logic [7:0] ByteMsb = 8'b1000_0000;

  typedef struct packed {
    logic [PayloadW-1:0] payload;
    logic [1:0]          channel;
  } in_t;

  typedef struct packed {
    logic       first_half;
    logic       second_half;
    logic       is_start;
    logic [1:0] line_select;
    logic [7:0] check_byte;
    logic       last;
  } out_t;

  // one classified packet waiting for the line encoder
  typedef struct packed {
    logic [FrameBits-1:0] frame;
    logic [1:0]           line;
  } job_t;

  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if ((c & ByteMsb) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: src/mcft_front.sv
// Front end: takes a packet and works out its CRC-8, one byte per cycle.
module mcft_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mcft_pkg::in_t in_data_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output mcft_pkg::job_t push_data_o
);
  import mcft_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CRC  = 3'b010,
    F_PUSH = 3'b100
  } front_state_e;

  front_state_e        state_q, state_d;
  logic [ByteIdxW-1:0] idx_q, idx_d;
  logic [PayloadW-1:0] pay_q, pay_d;
  logic [PayloadW-1:0] sh_q, sh_d;
  logic [7:0]          crc_q, crc_d;
  logic [1:0]          line_q, line_d;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    pay_d        = pay_q;
    sh_d         = sh_q;
    crc_d        = crc_q;
    line_d       = line_q;
    in_ready_o   = 1'b0;
    push_valid_o = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          pay_d   = in_data_i.payload;
          sh_d    = in_data_i.payload;
          line_d  = in_data_i.channel;
          crc_d   = CrcInit;
          idx_d   = '0;
          state_d = F_CRC;
        end
      end
      F_CRC: begin
        crc_d = crc8_byte(crc_q, sh_q[PayloadW-1 -: 8]);
        sh_d  = sh_q << 8;
        idx_d = idx_q + ByteIdxW'(1);
        if (idx_q == ByteIdxW'(PayloadBytes - 1)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        push_valid_o = 1'b1;
        if (push_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign push_data_o.frame = {pay_q, crc_q};
  assign push_data_o.line  = line_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    pay_q  <= pay_d;
    sh_q   <= sh_d;
    crc_q  <= crc_d;
    line_q <= line_d;
  end

endmodule

FILE: src/mcft_fifo.sv
// Two-entry queue of packets between the CRC front end and the line encoder.
module mcft_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  mcft_pkg::job_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output mcft_pkg::job_t pop_data_o
);
  import mcft_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: src/mcft_back.sv
// Back end: turns a queued frame into a start cell and one Manchester cell per bit.
module mcft_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  mcft_pkg::job_t pop_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mcft_pkg::out_t out_data_o
);
  import mcft_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_SEND = 2'b10
  } back_state_e;

  back_state_e          state_q, state_d;
  logic [CellCntW-1:0]  cnt_q;
  logic [FrameBits-1:0] sh_q;
  logic [7:0]           crc_q;
  logic [1:0]           line_q;
  logic                 ov_q;
  out_t                 out_q;
  out_t                 out_d;
  logic                 adv, fin, bit_v, load;

  assign adv   = (state_q == B_SEND) && (!ov_q || out_ready_i);
  assign fin   = (cnt_q == CellCntW'(FrameBits));
  assign bit_v = sh_q[FrameBits-1];
  assign load  = pop_valid_i && ((state_q == B_IDLE) || (adv && fin));
  assign pop_ready_o = (state_q == B_IDLE) || (adv && fin);

  always_comb begin
    out_d.line_select = line_q;
    if (cnt_q == '0) begin
      out_d.first_half  = 1'b0;
      out_d.second_half = 1'b1;
      out_d.is_start    = 1'b1;
      out_d.check_byte  = 8'h00;
      out_d.last        = 1'b0;
    end else begin
      out_d.first_half  = ~bit_v;
      out_d.second_half = bit_v;
      out_d.is_start    = 1'b0;
      out_d.check_byte  = fin ? crc_q : 8'h00;
      out_d.last        = fin;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:  if (load) state_d = B_SEND;
      B_SEND:  if (adv && fin && !load) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (adv) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
    if (load) begin
      sh_q   <= pop_data_i.frame;
      crc_q  <= pop_data_i.frame[7:0];
      line_q <= pop_data_i.line;
      cnt_q  <= '0;
    end else if (adv) begin
      // start cell leaves the frame untouched
      if (cnt_q != '0) sh_q <= sh_q << 1;
      cnt_q <= cnt_q + CellCntW'(1);
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

endmodule

FILE: src/manchester_crc8_frame_tx.sv
// Throughput: one line cell per cycle while out_ready_i is high; the cell encoder sets the packet rate.
// The CRC front end runs ahead of the cell encoder through a two-entry queue.
// Reset (rst_ni, asynchronous, active low) empties the queue and idles both ends.
// Top level: Manchester frame transmitter with CRC-8 check byte.
module manchester_crc8_frame_tx (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mcft_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mcft_pkg::out_t out_data_o
);
  import mcft_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_data, pop_data;

  mcft_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  mcft_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  mcft_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // every data cell has a mid-cell transition
  a_cell_transition: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_start |-> out_data_o.first_half != out_data_o.second_half)
    else $error("data cell without mid-cell transition");

  a_start_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_start |->
      !out_data_o.first_half && out_data_o.second_half && !out_data_o.last)
    else $error("malformed start cell");

  a_check_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> out_data_o.check_byte == 8'h00)
    else $error("check byte shown before the last cell");

  // after the last cell the next frame must open with a start cell
  a_start_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.last |=> !out_valid_o || out_data_o.is_start)
    else $error("frame does not open with a start cell");

endmodule

FILE: bench/tb.sv
// Self-checking bench for the Manchester CRC-8 frame transmitter.
`timescale 1ns / 100ps

module tb;
  import mcft_pkg::*;

  localparam int unsigned NumRandom  = 340;
  localparam int unsigned PauseAt    = 150;   // sender drains the line here once
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned NumRows    = 20;

  typedef struct packed {
    logic [PayloadW-1:0] payload;
    logic [1:0]          channel;
    logic                crc_known;
    logic [7:0]          crc;
  } pkt_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  out_t        exp_cells[$];
  int unsigned err_cnt = 0;
  int unsigned rx_stall = 0;
  int unsigned rx_phase = 0;
  logic        rx_steady = 1'b0;
  pkt_row_t    pkt_rows[NumRows];

  manchester_crc8_frame_tx u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // bit-serial CRC over the payload, MSB of the first byte first
  function automatic logic [7:0] crc8_of(input logic [PayloadW-1:0] pl);
    logic [7:0] c;
    logic       fb;
    c = CrcInit;
    for (int i = PayloadW - 1; i >= 0; i--) begin
      fb = c[7] ^ pl[i];
      c  = {c[6:0], 1'b0};
      if (fb) c = c ^ CrcPoly;
    end
    return c;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 10);
    else return $urandom_range(20, 30);
  endfunction

  function automatic logic [PayloadW-1:0] rand_payload();
    logic [PayloadW-1:0] p;
    logic [7:0]          b;
    case ($urandom_range(0, 9))
      0: p = $urandom_range(0, 1) ? '1 : '0;
      1: p = {{(PayloadW-1){1'b0}}, 1'b1} << $urandom_range(0, PayloadW - 1);
      2: p = ~({{(PayloadW-1){1'b0}}, 1'b1} << $urandom_range(0, PayloadW - 1));
      3: begin
        b = 8'($urandom_range(0, 255));
        p = {PayloadBytes{b}};
      end
      default: p = PayloadW'($urandom);
    endcase
    return p;
  endfunction

  // start cell then 32 bit cells; check byte only on the last one
  task automatic push_frame(input logic [PayloadW-1:0] pl, input logic [1:0] ch,
                            input logic [7:0] crc);
    logic [FrameBits-1:0] bits;
    out_t                 c;
    bits = {pl, crc};
    c = '0;
    c.first_half  = 1'b0;
    c.second_half = 1'b1;
    c.is_start    = 1'b1;
    c.line_select = ch;
    exp_cells.push_back(c);
    for (int i = FrameBits - 1; i >= 0; i--) begin
      c             = '0;
      c.first_half  = ~bits[i];
      c.second_half = bits[i];
      c.line_select = ch;
      if (i == 0) begin
        c.check_byte = crc;
        c.last       = 1'b1;
      end
      exp_cells.push_back(c);
    end
  endtask

  // entered and left at a falling edge
  task automatic send_packet(input logic [PayloadW-1:0] pl, input logic [1:0] ch,
                             input logic [7:0] crc, input int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i.payload <= pl;
    in_data_i.channel <= ch;
    in_valid_i        <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    push_frame(pl, ch, crc);
    @(negedge clk_i);
  endtask

  // receiver: random stalls, with stretches of steady ready
  always @(negedge clk_i) begin
    if (rx_phase == 300) begin
      rx_phase  <= 0;
      rx_steady <= ($urandom_range(0, 2) == 0);
    end else begin
      rx_phase <= rx_phase + 1;
    end
    if (rx_stall > 0) begin
      out_ready_i <= 1'b0;
      rx_stall    <= rx_stall - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (!rx_steady && $urandom_range(0, 3) == 0) rx_stall <= gap_len();
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (exp_cells.size() == 0) begin
        $display("%0t: unexpected cell, expected none, actual %h", $time, out_data_o);
        err_cnt <= err_cnt + 1;
      end else begin
        want = exp_cells.pop_front();
        if (out_data_o !== want) begin
          $display("%0t: cell mismatch, expected fh=%b sh=%b st=%b ln=%0d chk=%h lst=%b",
                   $time, want.first_half, want.second_half, want.is_start,
                   want.line_select, want.check_byte, want.last);
          $display("%0t:                  actual fh=%b sh=%b st=%b ln=%0d chk=%h lst=%b",
                   $time, out_data_o.first_half, out_data_o.second_half,
                   out_data_o.is_start, out_data_o.line_select,
                   out_data_o.check_byte, out_data_o.last);
          err_cnt <= err_cnt + 1;
        end
      end
    end
  end

  initial begin
    logic [PayloadW-1:0] pl;
    logic [7:0]          crc;
    // CRC typed in only where obvious: all-zero payload and a lone low bit
    pkt_rows[0]  = '{24'h000000, 2'd0, 1'b1, 8'h00};
    pkt_rows[1]  = '{24'h000001, 2'd1, 1'b1, 8'h07};
    pkt_rows[2]  = '{24'hFFFFFF, 2'd3, 1'b0, 8'h00};
    pkt_rows[3]  = '{24'h800000, 2'd2, 1'b0, 8'h00};
    pkt_rows[4]  = '{24'hAAAAAA, 2'd0, 1'b0, 8'h00};
    pkt_rows[5]  = '{24'h555555, 2'd1, 1'b0, 8'h00};
    pkt_rows[6]  = '{24'hFF0000, 2'd2, 1'b0, 8'h00};
    pkt_rows[7]  = '{24'h00FF00, 2'd3, 1'b0, 8'h00};
    pkt_rows[8]  = '{24'h0000FF, 2'd0, 1'b0, 8'h00};
    pkt_rows[9]  = '{24'h123456, 2'd1, 1'b0, 8'h00};
    pkt_rows[10] = '{24'h7FFFFF, 2'd2, 1'b0, 8'h00};
    pkt_rows[11] = '{24'hFFFFFE, 2'd3, 1'b0, 8'h00};
    pkt_rows[12] = '{24'h010000, 2'd0, 1'b0, 8'h00};
    pkt_rows[13] = '{24'h000100, 2'd1, 1'b0, 8'h00};
    pkt_rows[14] = '{24'hDEADBE, 2'd2, 1'b0, 8'h00};
    pkt_rows[15] = '{24'h0F0F0F, 2'd3, 1'b0, 8'h00};
    pkt_rows[16] = '{24'hF0F0F0, 2'd0, 1'b0, 8'h00};
    pkt_rows[17] = '{24'h000000, 2'd3, 1'b1, 8'h00};
    pkt_rows[18] = '{24'hFFFFFF, 2'd0, 1'b0, 8'h00};
    pkt_rows[19] = '{24'h000001, 2'd2, 1'b1, 8'h07};

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed rows back to back first, then with gaps
    for (int i = 0; i < NumRows; i++) begin
      crc = pkt_rows[i].crc_known ? pkt_rows[i].crc : crc8_of(pkt_rows[i].payload);
      send_packet(pkt_rows[i].payload, pkt_rows[i].channel, crc,
                  (i < 8) ? 0 : gap_len());
    end

    for (int i = 0; i < NumRandom; i++) begin
      if (i == PauseAt) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        while (exp_cells.size() != 0) @(negedge clk_i);
      end
      pl = rand_payload();
      send_packet(pl, 2'($urandom_range(0, 3)), crc8_of(pl),
                  ((i % 90) < 20 || i == PauseAt) ? 0 : gap_len());
    end
    in_valid_i <= 1'b0;

    while (exp_cells.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/mcft_pkg.sv
src/mcft_front.sv
src/mcft_fifo.sv
src/mcft_back.sv
src/manchester_crc8_frame_tx.sv
bench/tb.sv
